// ===== hw/rtl/spcal_pkg.sv =====
package spcal_pkg;

  localparam int POINTS = 3;

  localparam logic [1:0] MODE_CORRECT = 2'd0;
  localparam logic [1:0] MODE_SET     = 2'd1;
  localparam logic [1:0] MODE_KIND    = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_LINEAR = 2'd2;
  localparam logic [1:0] KIND_QUAD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_DEN, OP_DIV, OP_FIN
  } op_t;

  // operand = first - second, both taken from the fetched point pairs and the sample
  typedef enum logic [3:0] {
    SEL_S0, SEL_S1, SEL_S2, SEL_XR0, SEL_XR1, SEL_XR2,
    SEL_D12, SEL_D13, SEL_D23, SEL_D21, SEL_S1S0
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } uop_t;

  function automatic uop_t ucode(input logic [1:0] kind, input logic [4:0] pc);
    uop_t u;
    u = '{op: OP_FIN, sel: SEL_S0};
    case (kind)
      KIND_OFFSET: begin
        case (pc)
          5'd0: u = '{op: OP_LOAD, sel: SEL_XR0};
          5'd1: u = '{op: OP_ADD,  sel: SEL_S0};
          5'd2: u = '{op: OP_LOAD, sel: SEL_S0};
          5'd3: u = '{op: OP_ADD,  sel: SEL_S0};
          default: u = '{op: OP_FIN, sel: SEL_S0};
        endcase
      end
      KIND_LINEAR: begin
        case (pc)
          5'd0: u = '{op: OP_LOAD, sel: SEL_S0};
          5'd1: u = '{op: OP_MUL,  sel: SEL_D21};
          5'd2: u = '{op: OP_ADD,  sel: SEL_S0};
          5'd3: u = '{op: OP_LOAD, sel: SEL_XR0};
          5'd4: u = '{op: OP_MUL,  sel: SEL_S1S0};
          5'd5: u = '{op: OP_ADD,  sel: SEL_S0};
          5'd6: u = '{op: OP_LOAD, sel: SEL_D21};
          5'd7: u = '{op: OP_DEN,  sel: SEL_S0};
          5'd8: u = '{op: OP_DIV,  sel: SEL_S0};
          default: u = '{op: OP_FIN, sel: SEL_S0};
        endcase
      end
      KIND_QUAD: begin
        case (pc)
          5'd0:  u = '{op: OP_LOAD, sel: SEL_S0};
          5'd1:  u = '{op: OP_MUL,  sel: SEL_XR1};
          5'd2:  u = '{op: OP_MUL,  sel: SEL_XR2};
          5'd3:  u = '{op: OP_MUL,  sel: SEL_D23};
          5'd4:  u = '{op: OP_ADD,  sel: SEL_S0};
          5'd5:  u = '{op: OP_LOAD, sel: SEL_S1};
          5'd6:  u = '{op: OP_MUL,  sel: SEL_XR0};
          5'd7:  u = '{op: OP_MUL,  sel: SEL_XR2};
          5'd8:  u = '{op: OP_MUL,  sel: SEL_D13};
          5'd9:  u = '{op: OP_SUB,  sel: SEL_S0};
          5'd10: u = '{op: OP_LOAD, sel: SEL_S2};
          5'd11: u = '{op: OP_MUL,  sel: SEL_XR0};
          5'd12: u = '{op: OP_MUL,  sel: SEL_XR1};
          5'd13: u = '{op: OP_MUL,  sel: SEL_D12};
          5'd14: u = '{op: OP_ADD,  sel: SEL_S0};
          5'd15: u = '{op: OP_LOAD, sel: SEL_D12};
          5'd16: u = '{op: OP_MUL,  sel: SEL_D13};
          5'd17: u = '{op: OP_MUL,  sel: SEL_D23};
          5'd18: u = '{op: OP_DEN,  sel: SEL_S0};
          5'd19: u = '{op: OP_DIV,  sel: SEL_S0};
          default: u = '{op: OP_FIN, sel: SEL_S0};
        endcase
      end
      default: u = '{op: OP_FIN, sel: SEL_S0};
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/sensor_point_calibration.sv =====
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  mode, channel, point, cal_kind, value, adc_reading
// result    out        res_valid / res_ready  corrected, status
//
// Writes and pass-through go straight to the output stage; a correction adds a point fetch
// and a decide state, then runs a microprogram on one shared adder: each multiply is an
// issue step plus serial shift-add, the divide an issue step, serial steps, rounding and
// sign.
// Reset (rst, synchronous) clears all points, kinds and the result valid flag.
// req_ready is high only while idle; a finished result waits in the output register,
// and the next request is taken while it waits.
module sensor_point_calibration #(
  parameter int CHANNELS   = 5,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   mode,
  input  logic [2:0]                   channel,
  input  logic [1:0]                   point,
  input  logic [1:0]                   cal_kind,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic signed [VALUE_BITS-1:0] adc_reading,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [VALUE_BITS-1:0] corrected,
  output logic [1:0]                   status
);

  localparam int VB    = VALUE_BITS;
  localparam int DW    = VB + 1;
  localparam int W     = 4 * VB + 4;
  localparam int DEPTH = CHANNELS * spcal_pkg::POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW    = $clog2(W + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FETCH  = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_EXEC   = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_DIV    = 10'b0000100000,
    S_RND    = 10'b0001000000,
    S_RINC   = 10'b0010000000,
    S_RSGN   = 10'b0100000000,
    S_PUSH   = 10'b1000000000
  } state_t;

  state_t state;

  logic [VB-1:0] std_mem [DEPTH];
  logic [VB-1:0] raw_mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [1:0] kind_reg [CHANNELS];

  logic [VB-1:0] rd_std, rd_raw;
  logic          rd_vld;
  logic [AW-1:0] rd_addr, waddr, base;

  logic          accept, chok_in, ptok_in;
  logic [CW-1:0] ch_idx;

  logic [1:0]    kind_q;
  logic [2:0]    ch_q;
  logic [VB-1:0] x_q;
  logic [VB-1:0] sp [3];
  logic [VB-1:0] rp [3];

  logic [4:0]    pc;
  logic [NW-1:0] cnt;
  logic [W-1:0]  acc, prod, mcand, dmag, nsh, rem, q;
  logic [DW-1:0] mplier;
  logic          dneg, nneg, ge;
  logic [VB-1:0] res;
  logic [1:0]    st;

  spcal_pkg::uop_t uop;
  logic [VB-1:0] op_a, op_b;
  logic [DW-1:0] opnd;
  logic [W-1:0]  opnd_x, remshift;
  logic [W:0]    add_a, add_b, add_y;
  logic          add_sub;
  logic          in_range;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign chok_in   = int'(channel) < CHANNELS;
  assign ptok_in   = int'(point) < spcal_pkg::POINTS;
  assign ch_idx    = CW'(channel);
  assign waddr     = AW'(int'(channel) * spcal_pkg::POINTS + int'(point));
  assign base      = AW'(int'(ch_q) * spcal_pkg::POINTS);
  assign rd_addr   = base + AW'(cnt[1:0]);

  // point store
  always_ff @(posedge clk) begin
    if (accept && chok_in && ptok_in && mode == spcal_pkg::MODE_SET) begin
      std_mem[waddr] <= value;
      raw_mem[waddr] <= adc_reading;
    end
    if (state == S_FETCH && cnt < NW'(3)) begin
      rd_std <= std_mem[rd_addr];
      rd_raw <= raw_mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int i = 0; i < CHANNELS; i++) kind_reg[i] <= spcal_pkg::KIND_NONE;
    end else if (accept && chok_in) begin
      if (mode == spcal_pkg::MODE_SET && ptok_in) vld[waddr] <= 1'b1;
      if (mode == spcal_pkg::MODE_CLEAR && ptok_in) vld[waddr] <= 1'b0;
      if (mode == spcal_pkg::MODE_KIND) kind_reg[ch_idx] <= cal_kind;
    end
  end

  // operand select and difference
  assign uop = spcal_pkg::ucode(kind_q, pc);

  always_comb begin
    op_a = sp[0];
    op_b = '0;
    case (uop.sel)
      spcal_pkg::SEL_S0:   begin op_a = sp[0]; op_b = '0;    end
      spcal_pkg::SEL_S1:   begin op_a = sp[1]; op_b = '0;    end
      spcal_pkg::SEL_S2:   begin op_a = sp[2]; op_b = '0;    end
      spcal_pkg::SEL_XR0:  begin op_a = x_q;   op_b = rp[0]; end
      spcal_pkg::SEL_XR1:  begin op_a = x_q;   op_b = rp[1]; end
      spcal_pkg::SEL_XR2:  begin op_a = x_q;   op_b = rp[2]; end
      spcal_pkg::SEL_D12:  begin op_a = rp[0]; op_b = rp[1]; end
      spcal_pkg::SEL_D13:  begin op_a = rp[0]; op_b = rp[2]; end
      spcal_pkg::SEL_D23:  begin op_a = rp[1]; op_b = rp[2]; end
      spcal_pkg::SEL_D21:  begin op_a = rp[1]; op_b = rp[0]; end
      spcal_pkg::SEL_S1S0: begin op_a = sp[1]; op_b = sp[0]; end
      default:             begin op_a = sp[0]; op_b = '0;    end
    endcase
  end

  assign opnd     = {op_a[VB-1], op_a} - {op_b[VB-1], op_b};
  assign opnd_x   = {{(W-DW){opnd[DW-1]}}, opnd};
  assign remshift = {rem[W-2:0], nsh[W-1]};

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      S_MUL: begin
        add_a   = {prod[W-1], prod};
        add_b   = {mcand[W-1], mcand};
        add_sub = (cnt == NW'(DW - 1));
      end
      S_EXEC: begin
        case (uop.op)
          spcal_pkg::OP_ADD, spcal_pkg::OP_SUB: begin
            add_a   = {acc[W-1], acc};
            add_b   = {prod[W-1], prod};
            add_sub = (uop.op == spcal_pkg::OP_SUB);
          end
          spcal_pkg::OP_DEN: begin
            add_b   = {prod[W-1], prod};
            add_sub = prod[W-1];
          end
          spcal_pkg::OP_DIV: begin
            add_b   = {acc[W-1], acc};
            add_sub = acc[W-1];
          end
          default: add_sub = 1'b0;
        endcase
      end
      S_DIV: begin
        add_a   = {1'b0, remshift};
        add_b   = {1'b0, dmag};
        add_sub = 1'b1;
      end
      S_RND: begin
        add_a   = {1'b0, rem[W-2:0], 1'b0};
        add_b   = {1'b0, dmag};
        add_sub = 1'b1;
      end
      S_RINC: begin
        add_a = {1'b0, q};
        add_b = (W+1)'(ge);
      end
      S_RSGN: begin
        add_b   = {1'b0, q};
        add_sub = nneg ^ dneg;
      end
      default: add_sub = 1'b0;
    endcase
  end

  assign add_y    = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign in_range = (&acc[W-1:VB-1]) || !(|acc[W-1:VB-1]);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pc        <= '0;
      cnt       <= '0;
    end else begin
      if (res_valid && res_ready && state != S_PUSH) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            ch_q   <= channel;
            x_q    <= value;
            kind_q <= chok_in ? kind_reg[ch_idx] : spcal_pkg::KIND_NONE;
            cnt    <= '0;
            st     <= spcal_pkg::ST_OK;
            if (mode != spcal_pkg::MODE_CORRECT) begin
              res   <= '0;
              state <= S_PUSH;
            end else if (!chok_in) begin
              res   <= value;
              state <= S_PUSH;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (cnt != '0) begin
            sp[cnt[1:0] - 2'd1] <= rd_vld ? rd_std : '0;
            rp[cnt[1:0] - 2'd1] <= rd_vld ? rd_raw : '0;
          end
          cnt <= cnt + 1'b1;
          if (cnt == NW'(3)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          pc  <= '0;
          acc <= '0;
          res <= x_q;
          case (kind_q)
            spcal_pkg::KIND_OFFSET: state <= S_EXEC;
            spcal_pkg::KIND_LINEAR: begin
              if (rp[1] == rp[0]) begin
                st    <= spcal_pkg::ST_DEGEN;
                state <= S_PUSH;
              end else begin
                state <= S_EXEC;
              end
            end
            spcal_pkg::KIND_QUAD: begin
              if (rp[0] == rp[1] || rp[0] == rp[2] || rp[1] == rp[2]) begin
                st    <= spcal_pkg::ST_DEGEN;
                state <= S_PUSH;
              end else begin
                state <= S_EXEC;
              end
            end
            default: state <= S_PUSH;
          endcase
        end
        S_EXEC: begin
          case (uop.op)
            spcal_pkg::OP_LOAD: begin
              prod <= opnd_x;
              pc   <= pc + 1'b1;
            end
            spcal_pkg::OP_MUL: begin
              mcand  <= prod;
              prod   <= '0;
              mplier <= opnd;
              cnt    <= '0;
              state  <= S_MUL;
            end
            spcal_pkg::OP_ADD, spcal_pkg::OP_SUB: begin
              acc <= add_y[W-1:0];
              pc  <= pc + 1'b1;
            end
            spcal_pkg::OP_DEN: begin
              dmag <= add_y[W-1:0];
              dneg <= prod[W-1];
              pc   <= pc + 1'b1;
            end
            spcal_pkg::OP_DIV: begin
              nsh   <= add_y[W-1:0];
              nneg  <= acc[W-1];
              rem   <= '0;
              q     <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end
            default: begin
              if (in_range) begin
                res <= acc[VB-1:0];
              end else begin
                res <= acc[W-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
                st  <= spcal_pkg::ST_SAT;
              end
              state <= S_PUSH;
            end
          endcase
        end
        S_MUL: begin
          if (mplier[0]) prod <= add_y[W-1:0];
          mcand  <= {mcand[W-2:0], 1'b0};
          mplier <= {mplier[DW-1], mplier[DW-1:1]};
          cnt    <= cnt + 1'b1;
          if (cnt == NW'(DW - 1)) begin
            pc    <= pc + 1'b1;
            state <= S_EXEC;
          end
        end
        S_DIV: begin
          if (!add_y[W]) begin
            rem <= add_y[W-1:0];
            q   <= {q[W-2:0], 1'b1};
          end else begin
            rem <= remshift;
            q   <= {q[W-2:0], 1'b0};
          end
          nsh <= {nsh[W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == NW'(W - 1)) state <= S_RND;
        end
        S_RND: begin
          ge    <= !add_y[W];
          state <= S_RINC;
        end
        S_RINC: begin
          q     <= add_y[W-1:0];
          state <= S_RSGN;
        end
        S_RSGN: begin
          acc   <= add_y[W-1:0];
          pc    <= pc + 1'b1;
          state <= S_EXEC;
        end
        S_PUSH: begin
          if (!res_valid || res_ready) begin
            corrected <= res;
            status    <= st;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CHANNELS = 5;
  localparam int VBITS = 32;
  localparam logic signed [VBITS-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VBITS-1:0] VMIN = 32'sh80000000;

  typedef logic signed [191:0] big_t;

  typedef struct {
    logic [1:0] mode;
    logic [2:0] chan;
    logic [1:0] pt;
    logic [1:0] kind;
    logic signed [VBITS-1:0] val;
    logic signed [VBITS-1:0] adc;
    bit fixed;
    logic signed [VBITS-1:0] exp_corr;
    logic [1:0] exp_st;
  } req_t;

  typedef struct {
    logic signed [VBITS-1:0] corr;
    logic [1:0] st;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic [1:0] mode = '0;
  logic [2:0] channel = '0;
  logic [1:0] point = '0;
  logic [1:0] cal_kind = '0;
  logic signed [VBITS-1:0] value = '0;
  logic signed [VBITS-1:0] adc_reading = '0;
  logic res_valid;
  logic res_ready = 0;
  logic signed [VBITS-1:0] corrected;
  logic [1:0] status;

  req_t cur;
  req_t directed[$];
  res_t expected_q[$];
  logic signed [VBITS-1:0] cal_std[CHANNELS][3];
  logic signed [VBITS-1:0] cal_raw[CHANNELS][3];
  logic [1:0] chan_kind[CHANNELS];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_corr = 0;
  int n_sat = 0;
  int n_degen = 0;
  bit sending_done = 0;

  always #6 clk = ~clk;

  sensor_point_calibration #(.CHANNELS(CHANNELS), .VALUE_BITS(VBITS)) DUT (.*);

  initial begin
    cur = '{default: '0, fixed: 0};
    for (int c = 0; c < CHANNELS; c++) begin
      chan_kind[c] = spcal_pkg::KIND_NONE;
      for (int p = 0; p < 3; p++) begin
        cal_std[c][p] = '0;
        cal_raw[c][p] = '0;
      end
    end
  end

  function automatic res_t saturate(big_t a);
    res_t r;
    r.st = spcal_pkg::ST_OK;
    if (a > big_t'(VMAX)) begin
      r.corr = VMAX;
      r.st = spcal_pkg::ST_SAT;
    end else if (a < big_t'(VMIN)) begin
      r.corr = VMIN;
      r.st = spcal_pkg::ST_SAT;
    end else begin
      r.corr = a[VBITS-1:0];
    end
    return r;
  endfunction

  // nearest, ties away from zero
  function automatic big_t div_round(big_t n, big_t d);
    logic [191:0] an, ad, q, r;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = an / ad;
    r = an - q * ad;
    if ((r << 1) >= ad) q = q + 1;
    return ((n < 0) != (d < 0)) ? -big_t'(q) : big_t'(q);
  endfunction

  function automatic res_t correct_sample(int c, logic signed [VBITS-1:0] xv);
    big_t x, s0, s1, s2, r0, r1, r2, num, den;
    res_t r;
    x = xv;
    s0 = cal_std[c][0]; s1 = cal_std[c][1]; s2 = cal_std[c][2];
    r0 = cal_raw[c][0]; r1 = cal_raw[c][1]; r2 = cal_raw[c][2];
    r = '{corr: xv, st: spcal_pkg::ST_OK};
    case (chan_kind[c])
      spcal_pkg::KIND_OFFSET: r = saturate(x + s0 - r0);
      spcal_pkg::KIND_LINEAR: begin
        den = r1 - r0;
        if (den == 0) r.st = spcal_pkg::ST_DEGEN;
        else begin
          num = s0 * den + (x - r0) * (s1 - s0);
          r = saturate(div_round(num, den));
        end
      end
      spcal_pkg::KIND_QUAD: begin
        if (r0 == r1 || r0 == r2 || r1 == r2) r.st = spcal_pkg::ST_DEGEN;
        else begin
          num = s0 * (x - r1) * (x - r2) * (r1 - r2)
              - s1 * (x - r0) * (x - r2) * (r0 - r2)
              + s2 * (x - r0) * (x - r1) * (r0 - r1);
          den = (r0 - r1) * (r0 - r2) * (r1 - r2);
          r = saturate(div_round(num, den));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic res_t apply_request(req_t q);
    res_t r;
    bit chok, ptok;
    chok = q.chan < CHANNELS;
    ptok = q.pt < 3;
    r = '{corr: '0, st: spcal_pkg::ST_OK};
    case (q.mode)
      spcal_pkg::MODE_CORRECT: begin
        if (chok) r = correct_sample(q.chan, q.val);
        else r.corr = q.val;
      end
      spcal_pkg::MODE_SET:
        if (chok && ptok) begin
          cal_std[q.chan][q.pt] = q.val;
          cal_raw[q.chan][q.pt] = q.adc;
        end
      spcal_pkg::MODE_KIND: if (chok) chan_kind[q.chan] = q.kind;
      default:
        if (chok && ptok) begin
          cal_std[q.chan][q.pt] = '0;
          cal_raw[q.chan][q.pt] = '0;
        end
    endcase
    return r;
  endfunction

  task automatic report(string what, logic signed [VBITS-1:0] got,
                        logic signed [VBITS-1:0] exp);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp, n_res);
  endtask

  always @(posedge clk) begin
    res_t r;
    if (!rst && req_valid && req_ready) begin
      r = apply_request(cur);
      if (cur.fixed) r = '{corr: cur.exp_corr, st: cur.exp_st};
      if (cur.mode == spcal_pkg::MODE_CORRECT) n_corr++;
      if (r.st == spcal_pkg::ST_SAT) n_sat++;
      if (r.st == spcal_pkg::ST_DEGEN) n_degen++;
      expected_q.push_back(r);
      n_req++;
    end
    if (!rst && res_valid && res_ready) begin
      if (expected_q.size() == 0) report("unexpected result", corrected, '0);
      else begin
        r = expected_q.pop_front();
        if (corrected !== r.corr) report("corrected", corrected, r.corr);
        if (status !== r.st) report("status", VBITS'(status), VBITS'(r.st));
      end
      n_res++;
    end
  end

  task automatic send(req_t q);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    cur = q;
    mode <= q.mode;
    channel <= q.chan;
    point <= q.pt;
    cal_kind <= q.kind;
    value <= q.val;
    adc_reading <= q.adc;
    req_valid <= 1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [VBITS-1:0] rnd_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      2: return $signed($urandom_range(0, 512)) - 256;
      3: return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return $signed($urandom_range(0, 2 << 24)) - (1 << 24);
    endcase
  endfunction

  function automatic req_t mk(logic [1:0] m, logic [2:0] c, logic [1:0] p, logic [1:0] k,
                              logic signed [VBITS-1:0] v, logic signed [VBITS-1:0] a);
    return '{mode: m, chan: c, pt: p, kind: k, val: v, adc: a,
             fixed: 0, exp_corr: '0, exp_st: spcal_pkg::ST_OK};
  endfunction

  function automatic req_t mkx(logic [1:0] m, logic [2:0] c, logic [1:0] p, logic [1:0] k,
                               logic signed [VBITS-1:0] v, logic signed [VBITS-1:0] a,
                               logic signed [VBITS-1:0] ec, logic [1:0] es);
    req_t q;
    q = mk(m, c, p, k, v, a);
    q.fixed = 1;
    q.exp_corr = ec;
    q.exp_st = es;
    return q;
  endfunction

  initial begin
    req_t q;
    int n;
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 0, 0, 0, VMAX, 0, VMAX, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 0, 0, 0, VMIN, -1, VMIN, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 7, 3, 3, 123, 0, 123, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_KIND, 0, 0, spcal_pkg::KIND_NONE, 0, 0, 0,
                           spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_KIND, 2, 0, spcal_pkg::KIND_LINEAR, 0, 0, 0,
                           spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 2, 0, 0, 5, 0, 5, spcal_pkg::ST_DEGEN));
    directed.push_back(mkx(spcal_pkg::MODE_KIND, 3, 0, spcal_pkg::KIND_QUAD, 0, 0, 0,
                           spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 3, 0, 0, -7, 0, -7, spcal_pkg::ST_DEGEN));
    directed.push_back(mkx(spcal_pkg::MODE_SET, 1, 0, 0, VMAX, VMIN, 0, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_KIND, 1, 0, spcal_pkg::KIND_OFFSET, 0, 0, 0,
                           spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 1, 0, 0, 0, 0, VMAX, spcal_pkg::ST_SAT));
    directed.push_back(mk(spcal_pkg::MODE_CORRECT, 1, 0, 0, VMIN, 0));
    directed.push_back(mkx(spcal_pkg::MODE_SET, 1, 3, 0, 1, 2, 0, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_KIND, 7, 0, spcal_pkg::KIND_QUAD, 0, 0, 0,
                           spcal_pkg::ST_OK));
    directed.push_back(mk(spcal_pkg::MODE_CORRECT, 1, 0, 0, -5, 0));
    directed.push_back(mk(spcal_pkg::MODE_SET, 4, 0, 0, 0, 0));
    directed.push_back(mk(spcal_pkg::MODE_SET, 4, 1, 0, 32'h20000, 32'h10000));
    directed.push_back(mk(spcal_pkg::MODE_SET, 4, 2, 0, 32'h80000, 32'h20000));
    directed.push_back(mk(spcal_pkg::MODE_KIND, 4, 0, spcal_pkg::KIND_QUAD, 0, 0));
    directed.push_back(mk(spcal_pkg::MODE_CORRECT, 4, 0, 0, 32'h18000, 0));
    directed.push_back(mk(spcal_pkg::MODE_KIND, 4, 0, spcal_pkg::KIND_LINEAR, 0, 0));
    directed.push_back(mk(spcal_pkg::MODE_CORRECT, 4, 0, 0, -32'sh28000, 0));
    directed.push_back(mkx(spcal_pkg::MODE_CLEAR, 4, 1, 0, 0, 0, 0, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CLEAR, 4, 3, 0, 0, 0, 0, spcal_pkg::ST_OK));
    directed.push_back(mkx(spcal_pkg::MODE_CORRECT, 4, 0, 0, 99, 0, 99, spcal_pkg::ST_DEGEN));

    repeat (3) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (directed[i]) send(directed[i]);

    n = 0;
    while (n < 500) begin
      if ($urandom_range(0, 4) != 0) begin
        q = mk(spcal_pkg::MODE_SET, 3'($urandom_range(0, CHANNELS - 1)), 2'd0, 2'd0, 0, 0);
        for (int p = 0; p < 3; p++) begin
          q.pt = 2'(p);
          q.val = rnd_value();
          q.adc = ($urandom_range(0, 9) == 0) ? '0 : rnd_value();
          send(q);
          n++;
        end
        q.mode = spcal_pkg::MODE_KIND;
        q.kind = 2'($urandom_range(0, 3));
        send(q);
        n++;
        q.mode = spcal_pkg::MODE_CORRECT;
        repeat ($urandom_range(1, 4)) begin
          q.val = rnd_value();
          q.pt = 2'($urandom_range(0, 3));
          q.kind = 2'($urandom_range(0, 3));
          q.adc = $urandom;
          send(q);
          n++;
        end
      end else begin
        q = mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)), $urandom, $urandom);
        send(q);
        n++;
      end
    end
    req_valid <= 0;
    sending_done = 1;
  end

  initial begin
    bit held;
    held = 0;
    @(negedge clk);
    forever begin
      if (!held && n_res >= 60) begin
        held = 1;
        res_ready <= 0;
        repeat (1500) @(negedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        res_ready <= 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      res_ready <= 1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  initial begin
    wait (sending_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Ran %0d requests (%0d corrections), checked %0d results.", n_req, n_corr, n_res);
    $display("Saturated results: %0d, degenerate point sets: %0d.", n_sat, n_degen);
    if (errors == 0) $display("sensor_point_calibration verification clean");
    else $display("sensor_point_calibration verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding.", expected_q.size());
    $display("sensor_point_calibration verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spcal_pkg.sv
hw/rtl/sensor_point_calibration.sv
tb/tb.sv
